// File: src/assert_macros.svh
// assertion macros used by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define CIA_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("cia assertion failed");

// consequent must hold in the same cycle as the antecedent
`define CIA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cia assertion failed");

`endif

// File: src/cia_pkg.sv
// types, constants and helpers for the cell identity to ascii unit
package cia_pkg;

   localparam int REC_BYTES = 7;
   localparam int BYTE_W    = 8;
   localparam int DIGITS    = 5;
   localparam int DIG_W     = 4;
   localparam int VAL_W     = 16;
   localparam int MAX_CHARS = 19;
   localparam int BUF_AW    = $clog2(MAX_CHARS + 1);

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FORMAT  = 2'd1;
   localparam logic [1:0] ST_SIZE    = 2'd2;
   localparam logic [1:0] ST_VERSION = 2'd3;

   localparam logic [1:0] MODE_NO_PLMN = 2'd1;
   localparam logic [1:0] MODE_PLMN    = 2'd2;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_DASH  = 8'h2D;
   localparam logic [3:0] NIB_LIMIT   = 4'h9;
   localparam logic [3:0] NIB_END     = 4'hF;
   localparam logic [7:0] MIN_REC_LEN = 8'd7;
   localparam logic [7:0] ROOM_MCC    = 8'd5;
   localparam logic [7:0] ROOM_MNC    = 8'd3;

   typedef logic [DIGITS-1:0][DIG_W-1:0] bcd_type;

   typedef struct packed {
      logic [REC_BYTES-1:0][BYTE_W-1:0] rec_byte;
      logic [BYTE_W-1:0]                rec_len;
   } rec_type;

   typedef struct packed {
      logic    done;
      bcd_type digit;
   } dab_rsp_type;

   // number of significant decimal digits, at least one
   function automatic logic [2:0] digit_count(input bcd_type d);
      logic [2:0] cnt;
      cnt = 3'd1;
      for (int i = 1; i < DIGITS; i++) begin
         if (d[i] != '0) cnt = 3'(i + 1);
      end
      return cnt;
   endfunction

   function automatic logic [7:0] to_ascii(input logic [DIG_W-1:0] nib);
      return ASCII_ZERO + {4'd0, nib};
   endfunction

endpackage

// File: src/cia_dabble.sv
// iterative binary to bcd converter, one shift-add-3 step per cycle
module cia_dabble
   import cia_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] value,
   output dab_rsp_type      dab_rsp
);

   localparam logic [4:0] STEPS = 5'(VAL_W);

   logic [VAL_W-1:0]        shift_ff, shift_in;
   bcd_type                 bcd_ff, bcd_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIGITS*DIG_W-1:0] adj;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[i*DIG_W +: DIG_W] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = value;
         bcd_in   = '0;
         cnt_in   = STEPS;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bcd_in   = {adj[DIGITS*DIG_W-2:0], shift_ff[VAL_W-1]};
         shift_in = {shift_ff[VAL_W-2:0], 1'b0};
         cnt_in   = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
   end

   assign dab_rsp.done  = done_ff;
   assign dab_rsp.digit = bcd_ff;

endmodule

// File: src/cia_seq.sv
// sequencer: decodes the record into a text buffer, then streams it out, or returns one error beat
`include "assert_macros.svh"

module cia_seq
   import cia_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rec_type           req_rec,
   input  logic [1:0]        mode,
   input  logic [7:0]        capacity,
   output logic              dab_start,
   output logic [VAL_W-1:0]  dab_value,
   input  dab_rsp_type       dab_rsp,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_char,
   output logic [1:0]        rsp_status,
   output logic              rsp_last,
   output logic [7:0]        rsp_count
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_NIB      = 4'd1;
   localparam logic [3:0] S_FEND     = 4'd2;
   localparam logic [3:0] S_LAC_GO   = 4'd3;
   localparam logic [3:0] S_LAC_WAIT = 4'd4;
   localparam logic [3:0] S_LAC_DIG  = 4'd5;
   localparam logic [3:0] S_LAC_DASH = 4'd6;
   localparam logic [3:0] S_CI_WAIT  = 4'd7;
   localparam logic [3:0] S_CI_DIG   = 4'd8;
   localparam logic [3:0] S_RD       = 4'd9;
   localparam logic [3:0] S_LOAD     = 4'd10;
   localparam logic [3:0] S_ERR      = 4'd11;

   logic [3:0]        state_ff, state_in;
   logic [7:0]        room_ff, room_in;
   logic [BUF_AW-1:0] n_ff, n_in;
   logic [BUF_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0]        ptr_ff, ptr_in;
   logic [2:0]        pos_ff, pos_in;
   logic [2:0]        rem_ff, rem_in;
   logic [1:0]        err_ff, err_in;
   logic              mode2_ff, mode2_in;
   rec_type           rec_ff, rec_in;
   bcd_type           dig_ff, dig_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [7:0]        rsp_count_ff, rsp_count_in;

   logic [7:0]        buf_mem [MAX_CHARS];
   logic [7:0]        rd_data_ff;
   logic              wr_en;
   logic [7:0]        wr_char;

   logic              out_free;
   logic [7:0]        nib_byte;
   logic [3:0]        nib;
   logic [2:0]        dcnt;
   logic              last_char;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign dcnt      = digit_count(dab_rsp.digit);
   assign last_char = (rd_ptr_ff + BUF_AW'(1)) == n_ff;

   always_comb begin
      case (ptr_ff[2:1])
         2'd0:    nib_byte = rec_ff.rec_byte[0];
         2'd1:    nib_byte = rec_ff.rec_byte[1];
         default: nib_byte = rec_ff.rec_byte[2];
      endcase
      nib = ptr_ff[0] ? nib_byte[7:4] : nib_byte[3:0];
   end

   always_comb begin
      state_in      = state_ff;
      room_in       = room_ff;
      rd_ptr_in     = rd_ptr_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      err_in        = err_ff;
      mode2_in      = mode2_ff;
      rec_in        = rec_ff;
      dig_in        = dig_ff;
      wr_en         = 1'b0;
      wr_char       = ASCII_DASH;
      dab_start     = 1'b0;
      dab_value     = mode2_ff ? {rec_ff.rec_byte[3], rec_ff.rec_byte[4]}
                               : {rec_ff.rec_byte[0], rec_ff.rec_byte[1]};
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rec_in    = req_rec;
               room_in   = capacity;
               rd_ptr_in = '0;
               ptr_in    = '0;
               mode2_in  = (mode == MODE_PLMN);
               if (mode != MODE_PLMN && mode != MODE_NO_PLMN) begin
                  err_in   = ST_VERSION;
                  state_in = S_ERR;
               end else if (req_rec.rec_len < MIN_REC_LEN) begin
                  err_in   = ST_FORMAT;
                  state_in = S_ERR;
               end else if (mode == MODE_PLMN) begin
                  state_in = S_NIB;
               end else begin
                  state_in = S_LAC_GO;
               end
            end
         end
         S_NIB: begin
            if (ptr_ff[0] && nib == NIB_END) begin
               // filler nibble closes the field
               state_in = S_FEND;
            end else if (nib > NIB_LIMIT) begin
               err_in   = ST_FORMAT;
               state_in = S_ERR;
            end else if (room_ff == '0) begin
               err_in   = ST_SIZE;
               state_in = S_ERR;
            end else begin
               wr_en   = 1'b1;
               wr_char = to_ascii(nib);
               room_in = room_ff - 8'd1;
               if (ptr_ff == 3'd3 || ptr_ff == 3'd5) state_in = S_FEND;
               else ptr_in = ptr_ff + 3'd1;
            end
         end
         S_FEND: begin
            if (ptr_ff < 3'd4) begin
               if (room_ff <= ROOM_MCC) begin
                  err_in   = ST_SIZE;
                  state_in = S_ERR;
               end else begin
                  wr_en    = 1'b1;
                  room_in  = room_ff - 8'd1;
                  ptr_in   = 3'd4;
                  state_in = S_NIB;
               end
            end else begin
               if (room_ff <= ROOM_MNC) begin
                  err_in   = ST_SIZE;
                  state_in = S_ERR;
               end else begin
                  wr_en    = 1'b1;
                  room_in  = room_ff - 8'd1;
                  state_in = S_LAC_GO;
               end
            end
         end
         S_LAC_GO: begin
            dab_start = 1'b1;
            state_in  = S_LAC_WAIT;
         end
         S_LAC_WAIT: begin
            if (dab_rsp.done) begin
               if ({1'b0, room_ff} < {6'd0, dcnt} + 9'd1) begin
                  err_in   = ST_SIZE;
                  state_in = S_ERR;
               end else begin
                  dig_in   = dab_rsp.digit;
                  pos_in   = dcnt - 3'd1;
                  state_in = S_LAC_DIG;
               end
            end
         end
         S_LAC_DIG: begin
            wr_en   = 1'b1;
            wr_char = to_ascii(dig_ff[pos_ff]);
            room_in = room_ff - 8'd1;
            if (pos_ff == '0) state_in = S_LAC_DASH;
            else pos_in = pos_ff - 3'd1;
         end
         S_LAC_DASH: begin
            wr_en     = 1'b1;
            room_in   = room_ff - 8'd1;
            dab_start = 1'b1;
            dab_value = mode2_ff ? {rec_ff.rec_byte[5], rec_ff.rec_byte[6]}
                                 : {rec_ff.rec_byte[2], rec_ff.rec_byte[3]};
            state_in  = S_CI_WAIT;
         end
         S_CI_WAIT: begin
            if (dab_rsp.done) begin
               if ({5'd0, dcnt} > room_ff) begin
                  err_in   = ST_SIZE;
                  state_in = S_ERR;
               end else begin
                  dig_in = dab_rsp.digit;
                  pos_in = dcnt - 3'd1;
                  // no room left for the terminator: drop the last digit
                  if ({5'd0, dcnt} < room_ff) rem_in = dcnt;
                  else rem_in = room_ff[2:0] - 3'd1;
                  if ({5'd0, dcnt} == room_ff && dcnt == 3'd1) state_in = S_RD;
                  else state_in = S_CI_DIG;
               end
            end
         end
         S_CI_DIG: begin
            wr_en   = 1'b1;
            wr_char = to_ascii(dig_ff[pos_ff]);
            pos_in  = pos_ff - 3'd1;
            rem_in  = rem_ff - 3'd1;
            if (rem_ff == 3'd1) state_in = S_RD;
         end
         S_RD: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = rd_data_ff;
               rsp_status_in = ST_OK;
               rsp_last_in   = last_char;
               rsp_count_in  = last_char ? 8'(n_ff) : 8'd0;
               rd_ptr_in     = rd_ptr_ff + BUF_AW'(1);
               state_in      = last_char ? S_IDLE : S_RD;
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = 8'd0;
               rsp_status_in = err_ff;
               rsp_last_in   = 1'b1;
               rsp_count_in  = 8'd0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (state_ff == S_IDLE) n_in = '0;
      else n_in = n_ff + BUF_AW'(wr_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         rd_ptr_ff    <= '0;
         ptr_ff       <= '0;
         pos_ff       <= '0;
         rem_ff       <= '0;
         err_ff       <= ST_OK;
         mode2_ff     <= 1'b0;
         room_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         rd_ptr_ff    <= rd_ptr_in;
         ptr_ff       <= ptr_in;
         pos_ff       <= pos_in;
         rem_ff       <= rem_in;
         err_ff       <= err_in;
         mode2_ff     <= mode2_in;
         room_ff      <= room_in;
      end
      rec_ff        <= rec_in;
      dig_ff        <= dig_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // text buffer
   always_ff @(posedge clock) begin
      if (wr_en) buf_mem[n_ff] <= wr_char;
      rd_data_ff <= buf_mem[rd_ptr_ff];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_char   = rsp_char_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_count  = rsp_count_ff;

   `CIA_ASSERT_IMPLY(a_err_is_single, clock, reset,
      rsp_valid_ff && rsp_status_ff != ST_OK, rsp_last_ff && rsp_char_ff == 8'd0)
   `CIA_ASSERT_IMPLY(a_count_on_last_only, clock, reset,
      rsp_valid_ff && !rsp_last_ff, rsp_count_ff == 8'd0)
   `CIA_ASSERT_ALWAYS(a_buf_bound, clock, reset, n_ff <= BUF_AW'(MAX_CHARS))

endmodule

// File: src/cell_identity_to_ascii_unit.sv
// top level: csr block, stream ports, sequencer and shared bcd converter
// errors: a bad version or length is detected in the idle state, a bad digit while the
//   nibbles are read and a size error at the first field that does not fit the capacity
// text: plmn nibbles and dashes are written, then the lac digits and dash, then ci digits;
//   up to 19 chars then stream out, held by output stalls; next record after the last char
// reset: version_mode 2, out_capacity 18, sequencer idle, output empty; text buffer not cleared
module cell_identity_to_ascii_unit
   import cia_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // byte_0, byte_1, .. byte_6, record_length
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_char, char_count
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic REG_MODE = 1'b0;
   localparam logic REG_CAP  = 1'b1;

   logic [1:0]       mode_ff, mode_in;
   logic [7:0]       cap_ff, cap_in;
   logic             csr_wr;
   rec_type          rec;
   logic             dab_start;
   logic [VAL_W-1:0] dab_value;
   dab_rsp_type      dab_rsp;
   logic [7:0]       out_char;
   logic [7:0]       char_count;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in = mode_ff;
      cap_in  = cap_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_MODE: mode_in = csr_pwdata[1:0];
            REG_CAP:  cap_in  = csr_pwdata[7:0];
            default:  mode_in = mode_ff;
         endcase
      end
      unique case (csr_paddr[2])
         REG_MODE: csr_prdata = {30'd0, mode_ff};
         REG_CAP:  csr_prdata = {24'd0, cap_ff};
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLMN;
         cap_ff  <= 8'd18;
      end else begin
         mode_ff <= mode_in;
         cap_ff  <= cap_in;
      end
   end

   assign rec.rec_byte = req_tdata[55:0];
   assign rec.rec_len  = req_tdata[63:56];

   cia_dabble u_dabble (
      .clock   (clock),
      .reset   (reset),
      .start   (dab_start),
      .value   (dab_value),
      .dab_rsp (dab_rsp)
   );

   cia_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_rec    (rec),
      .mode       (mode_ff),
      .capacity   (cap_ff),
      .dab_start  (dab_start),
      .dab_value  (dab_value),
      .dab_rsp    (dab_rsp),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_char   (out_char),
      .rsp_status (rsp_tuser),
      .rsp_last   (rsp_tlast),
      .rsp_count  (char_count)
   );

   assign rsp_tdata = {char_count, out_char};

endmodule
